// ===== rtl/gba_pkg.sv =====
// Shared types, constants and the arctangent table for the grid bearing pipeline.
package gba_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int DELTA_WIDTH     = COORD_WIDTH + 1;
   localparam int GUARD_BITS      = 24;
   localparam int XY_WIDTH        = COORD_WIDTH + GUARD_BITS + 3;
   localparam int ANGLE_WIDTH     = 25;
   localparam int BEARING_WIDTH   = 17;
   localparam int ANGLE_TABLE_LEN = 24;
   localparam int ROUND_SHIFT     = 8;

   localparam logic signed [ANGLE_WIDTH-1:0] ROUND_HALF = ANGLE_WIDTH'(128);
   localparam logic signed [BEARING_WIDTH:0] HALF_TURN  = (BEARING_WIDTH+1)'(46080);

   localparam logic signed [ANGLE_WIDTH-1:0] STAGE_ANGLE [ANGLE_TABLE_LEN] = '{
      ANGLE_WIDTH'(2949120), ANGLE_WIDTH'(1740967), ANGLE_WIDTH'(919879),
      ANGLE_WIDTH'(466945),  ANGLE_WIDTH'(234379),  ANGLE_WIDTH'(117304),
      ANGLE_WIDTH'(58666),   ANGLE_WIDTH'(29335),   ANGLE_WIDTH'(14668),
      ANGLE_WIDTH'(7334),    ANGLE_WIDTH'(3667),    ANGLE_WIDTH'(1833),
      ANGLE_WIDTH'(917),     ANGLE_WIDTH'(458),     ANGLE_WIDTH'(229),
      ANGLE_WIDTH'(115),     ANGLE_WIDTH'(57),      ANGLE_WIDTH'(29),
      ANGLE_WIDTH'(14),      ANGLE_WIDTH'(7),       ANGLE_WIDTH'(4),
      ANGLE_WIDTH'(2),       ANGLE_WIDTH'(1),       ANGLE_WIDTH'(0)
   };

   typedef enum logic [1:0] {
      BASE_NONE = 2'd0,
      BASE_POS  = 2'd1,
      BASE_NEG  = 2'd2
   } base_type;

   typedef struct packed {
      logic     valid;
      logic     zero_vector;
      base_type base;
   } ctrl_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] cur_lat;
      logic signed [COORD_WIDTH-1:0] cur_lon;
      logic signed [COORD_WIDTH-1:0] tgt_lat;
      logic signed [COORD_WIDTH-1:0] tgt_lon;
   } req_type;

   typedef struct packed {
      logic signed [BEARING_WIDTH-1:0] bearing;
      logic                            zero_vector;
   } rsp_type;

endpackage

// ===== rtl/grid_bearing_angle.sv =====
// Grid bearing unit: pipelined CORDIC atan2 of target minus current grid point.
//
// Input channel req_*: one item carries the current and target grid points
// (signed 16-bit latitude and longitude indices). Result channel rsp_*: one
// item per input, the bearing in 1/256 degree (-180..+180 degrees, signed
// 17 bits) and a zero_vector flag that is set, with bearing 0, when the two
// points coincide.
// An item is taken when valid is high and stall is low.
// The pipeline has two front-end stages (deltas, then half-plane turn), one
// stage per CORDIC iteration, and the rounding and saturation stage that
// also serves as the output register.
// Throughput is one item per cycle while no result is stalled; items follow each other back to back.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall is raised in the same cycle; nothing is lost or repeated.
// Synchronous reset clears all valid bits; no items are in flight after it.
module grid_bearing_angle #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gba_pkg::rsp_type rsp_data
);

   logic                                   en;
   gba_pkg::ctrl_type                      ctrl_p [CORDIC_STAGES+1];
   logic signed [gba_pkg::XY_WIDTH-1:0]    x_p    [CORDIC_STAGES+1];
   logic signed [gba_pkg::XY_WIDTH-1:0]    y_p    [CORDIC_STAGES+1];
   logic signed [gba_pkg::ANGLE_WIDTH-1:0] z_p    [CORDIC_STAGES+1];

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign z_p[0]    = '0;

   gba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .src_valid (req_valid),
      .src_data  (req_data),
      .dst_ctrl  (ctrl_p[0]),
      .dst_x     (x_p[0]),
      .dst_y     (y_p[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      gba_stage #(
         .STAGE_INDEX (i)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .src_ctrl (ctrl_p[i]),
         .src_x    (x_p[i]),
         .src_y    (y_p[i]),
         .src_z    (z_p[i]),
         .dst_ctrl (ctrl_p[i+1]),
         .dst_x    (x_p[i+1]),
         .dst_y    (y_p[i+1]),
         .dst_z    (z_p[i+1])
      );
   end

   gba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .src_ctrl  (ctrl_p[CORDIC_STAGES]),
      .src_z     (z_p[CORDIC_STAGES]),
      .dst_valid (rsp_valid),
      .dst_data  (rsp_data)
   );

   a_bearing_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.bearing <= 17'sd46080) && (rsp_data.bearing >= -17'sd46080))
      else $error("bearing out of range");

   a_zero_bearing : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_vector) |-> (rsp_data.bearing == '0))
      else $error("zero vector with nonzero bearing");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ===== rtl/gba_front.sv =====
// Front end: coordinate deltas, then half-plane turn and scaling into CORDIC format.
module gba_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  src_valid,
   input  gba_pkg::req_type                      src_data,
   output gba_pkg::ctrl_type                     dst_ctrl,
   output logic signed [gba_pkg::XY_WIDTH-1:0]   dst_x,
   output logic signed [gba_pkg::XY_WIDTH-1:0]   dst_y
);

   logic signed [gba_pkg::DELTA_WIDTH-1:0] dlat_ff, dlat_in;
   logic signed [gba_pkg::DELTA_WIDTH-1:0] dlon_ff, dlon_in;
   logic                                   valid_ff, zero_ff;
   gba_pkg::ctrl_type                      ctrl_ff, ctrl_in;
   logic signed [gba_pkg::XY_WIDTH-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [gba_pkg::XY_WIDTH-1:0]    lat_ext, lon_ext;

   always_comb begin
      dlat_in = gba_pkg::DELTA_WIDTH'(src_data.tgt_lat) - gba_pkg::DELTA_WIDTH'(src_data.cur_lat);
      dlon_in = gba_pkg::DELTA_WIDTH'(src_data.tgt_lon) - gba_pkg::DELTA_WIDTH'(src_data.cur_lon);
   end

   always_comb begin
      lat_ext = gba_pkg::XY_WIDTH'(dlat_ff) <<< gba_pkg::GUARD_BITS;
      lon_ext = gba_pkg::XY_WIDTH'(dlon_ff) <<< gba_pkg::GUARD_BITS;
      ctrl_in.valid       = valid_ff;
      ctrl_in.zero_vector = zero_ff;
      if (dlon_ff < 0) begin
         x_in = -lon_ext;
         y_in = -lat_ext;
         ctrl_in.base = (dlat_ff >= 0) ? gba_pkg::BASE_POS : gba_pkg::BASE_NEG;
      end else begin
         x_in = lon_ext;
         y_in = lat_ext;
         ctrl_in.base = gba_pkg::BASE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ctrl_ff  <= '0;
      end else if (en) begin
         valid_ff <= src_valid;
         ctrl_ff  <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dlat_ff <= dlat_in;
         dlon_ff <= dlon_in;
         zero_ff <= (dlat_in == '0) && (dlon_in == '0);
         x_ff    <= x_in;
         y_ff    <= y_in;
      end
   end

   assign dst_ctrl = ctrl_ff;
   assign dst_x    = x_ff;
   assign dst_y    = y_ff;

endmodule

// ===== rtl/gba_stage.sv =====
// One registered CORDIC vectoring iteration.
module gba_stage #(
   parameter int STAGE_INDEX = 0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  gba_pkg::ctrl_type                       src_ctrl,
   input  logic signed [gba_pkg::XY_WIDTH-1:0]     src_x,
   input  logic signed [gba_pkg::XY_WIDTH-1:0]     src_y,
   input  logic signed [gba_pkg::ANGLE_WIDTH-1:0]  src_z,
   output gba_pkg::ctrl_type                       dst_ctrl,
   output logic signed [gba_pkg::XY_WIDTH-1:0]     dst_x,
   output logic signed [gba_pkg::XY_WIDTH-1:0]     dst_y,
   output logic signed [gba_pkg::ANGLE_WIDTH-1:0]  dst_z
);

   localparam logic signed [gba_pkg::ANGLE_WIDTH-1:0] ANGLE = gba_pkg::STAGE_ANGLE[STAGE_INDEX];

   gba_pkg::ctrl_type                        ctrl_ff;
   logic signed [gba_pkg::XY_WIDTH-1:0]      x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [gba_pkg::ANGLE_WIDTH-1:0]   z_ff, z_in;

   always_comb begin
      xs = src_x >>> STAGE_INDEX;
      ys = src_y >>> STAGE_INDEX;
      x_in = src_x;
      y_in = src_y;
      z_in = src_z;
      if (src_y > 0) begin
         x_in = src_x + ys;
         y_in = src_y - xs;
         z_in = src_z + ANGLE;
      end else if (src_y < 0) begin
         x_in = src_x - ys;
         y_in = src_y + xs;
         z_in = src_z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= src_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dst_ctrl = ctrl_ff;
   assign dst_x    = x_ff;
   assign dst_y    = y_ff;
   assign dst_z    = z_ff;

endmodule

// ===== rtl/gba_back.sv =====
// Back end: round the angle to 1/256 degree, add the half-turn base, saturate.
module gba_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  gba_pkg::ctrl_type                       src_ctrl,
   input  logic signed [gba_pkg::ANGLE_WIDTH-1:0]  src_z,
   output logic                                    dst_valid,
   output gba_pkg::rsp_type                        dst_data
);

   localparam int QW = gba_pkg::ANGLE_WIDTH - gba_pkg::ROUND_SHIFT;
   localparam int SW = gba_pkg::BEARING_WIDTH + 1;

   logic                                   valid_ff;
   gba_pkg::rsp_type                       data_ff, data_in;
   logic signed [gba_pkg::ANGLE_WIDTH-1:0] zr;
   logic signed [QW-1:0]                   q;
   logic signed [SW-1:0]                   base, sum, sat;

   always_comb begin
      zr = src_z + gba_pkg::ROUND_HALF;
      q  = QW'(zr >>> gba_pkg::ROUND_SHIFT);
      case (src_ctrl.base)
         gba_pkg::BASE_POS: base = gba_pkg::HALF_TURN;
         gba_pkg::BASE_NEG: base = -gba_pkg::HALF_TURN;
         default:           base = '0;
      endcase
      sum = SW'(q) + base;
      if (sum > gba_pkg::HALF_TURN) begin
         sat = gba_pkg::HALF_TURN;
      end else if (sum < -gba_pkg::HALF_TURN) begin
         sat = -gba_pkg::HALF_TURN;
      end else begin
         sat = sum;
      end
      data_in.zero_vector = src_ctrl.zero_vector;
      data_in.bearing     = src_ctrl.zero_vector ? '0 : sat[gba_pkg::BEARING_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= src_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_data  = data_ff;

endmodule
